>>> rtl/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg: shared types and constants for the top-k insertion list
// Widths, list depth, request kinds, controller states and cell control.
// ----------------------------------------------------------------------------
package tksi_pkg;

  localparam int DEPTH   = 10;
  localparam int SCORE_W = 16;
  localparam int TAG_W   = 16;
  localparam int KIND_W  = 2;
  localparam int RANK_W  = 4;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [KIND_W-1:0] KIND_OFFER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic offer;   // insert/shift pass for a non-zero candidate
    logic rotate;  // report pass: occupied cells move one place towards the head
  } cell_ctl_t;

endpackage

>>> rtl/tksi_cell.sv
// ----------------------------------------------------------------------------
// tksi_cell: one slot of the sorted list
// Holds a score and tag; inserts the candidate, takes its upper neighbour on
// a shift, or takes its rotation source during a report.
// ----------------------------------------------------------------------------
module tksi_cell (
  input  logic                          clk,
  input  tksi_pkg::cell_ctl_t           ctl,
  input  logic                          occupied,
  input  logic [tksi_pkg::SCORE_W-1:0]  cand_score,
  input  logic [tksi_pkg::TAG_W-1:0]    cand_tag,
  input  logic                          ins_prev,
  input  logic [tksi_pkg::SCORE_W-1:0]  prev_score,
  input  logic [tksi_pkg::TAG_W-1:0]    prev_tag,
  input  logic [tksi_pkg::SCORE_W-1:0]  rot_score,
  input  logic [tksi_pkg::TAG_W-1:0]    rot_tag,
  output logic                          ins,
  output logic [tksi_pkg::SCORE_W-1:0]  score,
  output logic [tksi_pkg::TAG_W-1:0]    tag
);
  import tksi_pkg::*;

  // strict compare keeps an earlier equal score ahead
  assign ins = ctl.offer && (!occupied || (score < cand_score));

  always_ff @(posedge clk) begin
    if (ins) begin
      if (ins_prev) begin
        score <= prev_score;
        tag   <= prev_tag;
      end else begin
        score <= cand_score;
        tag   <= cand_tag;
      end
    end else if (ctl.rotate && occupied) begin
      score <= rot_score;
      tag   <= rot_tag;
    end
  end

endmodule

>>> rtl/top_k_sorted_insertion.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insertion: best-DEPTH candidate list in descending score order
// Chain of slot cells with a small report sequencer and one output register.
// ----------------------------------------------------------------------------
// An offer or clear request is completed when it is taken: for an offer, every
// cell compares the candidate in parallel and the chain shifts once, so
// offers stream at one per cycle while results are taken. A report request
// blocks the input after it is taken until all held entries are delivered
// (not at all when the list is empty), the chain rotating one place per
// delivered result with the head cell feeding the output; after the pass
// the list is back in its original order. Output stall holds back both the
// report pass and new requests. A clear or an unused kind gives no result.
module top_k_sorted_insertion (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tksi_pkg::KIND_W-1:0]   kind,
  input  logic [tksi_pkg::SCORE_W-1:0]  cand_score,
  input  logic [tksi_pkg::TAG_W-1:0]    cand_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic [tksi_pkg::RANK_W-1:0]   rank,
  output logic [tksi_pkg::SCORE_W-1:0]  entry_score,
  output logic [tksi_pkg::TAG_W-1:0]    entry_tag,
  output logic                          entry_valid,
  output logic                          last
);
  import tksi_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   held_count;
  logic [IDX_W-1:0]   rep_idx;
  logic               in_acc, out_free, offer_go, rep_last;
  logic [IDX_W-1:0]   ins_pos;
  cell_ctl_t          ctl;

  logic [DEPTH-1:0]   ins;
  logic [DEPTH-1:0]   occupied;
  logic [SCORE_W-1:0] cell_score [DEPTH];
  logic [TAG_W-1:0]   cell_tag   [DEPTH];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign offer_go = in_acc && (kind == KIND_OFFER) && (cand_score != '0);
  assign rep_last = ((CNT_W'(rep_idx) + CNT_W'(1)) == held_count);

  assign ctl.offer  = offer_go;
  assign ctl.rotate = (state == ST_REPORT) && out_free;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               ip;
    logic [SCORE_W-1:0] ps, rs;
    logic [TAG_W-1:0]   pt, rt;

    assign occupied[i] = (CNT_W'(i) < held_count);

    if (i == 0) begin : g_head
      assign ip = 1'b0;
      assign ps = cand_score;
      assign pt = cand_tag;
    end else begin : g_body
      assign ip = ins[i-1];
      assign ps = cell_score[i-1];
      assign pt = cell_tag[i-1];
    end

    // the last occupied cell wraps round to the head
    if (i == DEPTH - 1) begin : g_tail
      assign rs = cell_score[0];
      assign rt = cell_tag[0];
    end else begin : g_mid
      assign rs = ((CNT_W'(i) + CNT_W'(1)) == held_count) ? cell_score[0] : cell_score[i+1];
      assign rt = ((CNT_W'(i) + CNT_W'(1)) == held_count) ? cell_tag[0]   : cell_tag[i+1];
    end

    tksi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occupied[i]),
      .cand_score (cand_score),
      .cand_tag   (cand_tag),
      .ins_prev   (ip),
      .prev_score (ps),
      .prev_tag   (pt),
      .rot_score  (rs),
      .rot_tag    (rt),
      .ins        (ins[i]),
      .score      (cell_score[i]),
      .tag        (cell_tag[i])
    );
  end

  // insert position: the one cell where the insert run starts
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins[i] && ((i == 0) || !ins[(i == 0) ? 0 : i-1])) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_REPORT) && (held_count != '0)) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free && rep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (in_acc && (kind == KIND_CLEAR)) begin
      held_count <= '0;
    end else if (offer_go && ins[DEPTH-1] && (held_count != CNT_W'(DEPTH))) begin
      held_count <= held_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rep_idx <= '0;
    end else if (out_free) begin
      rep_idx <= rep_idx + IDX_W'(1);
    end
  end

  // a report of a non-empty list delivers its results from the report pass
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_REPORT) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end
    end else if (in_acc && ((kind == KIND_OFFER) ||
                            ((kind == KIND_REPORT) && (held_count == '0)))) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPORT) begin
      if (out_free) begin
        accepted    <= 1'b0;
        rank        <= RANK_W'(rep_idx);
        entry_score <= cell_score[0];
        entry_tag   <= cell_tag[0];
        entry_valid <= 1'b1;
        last        <= rep_last;
      end
    end else if (in_acc) begin
      // offer result, or the single empty report result
      accepted    <= offer_go && ins[DEPTH-1];
      rank        <= (offer_go && ins[DEPTH-1]) ? RANK_W'(ins_pos) : '0;
      entry_score <= '0;
      entry_tag   <= '0;
      entry_valid <= 1'b0;
      last        <= 1'b1;
    end
  end

  a_report_blocks_input : assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT) |-> in_stall)
    else $error("request taken during report pass");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(DEPTH))
    else $error("held count beyond depth");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    (in_acc && (kind == KIND_CLEAR)) |=> (held_count == '0))
    else $error("clear did not empty the list");

  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (held_count >= CNT_W'(2)) && (DEPTH > 1))
      |-> (cell_score[0] >= cell_score[(DEPTH > 1) ? 1 : 0]))
    else $error("head cells out of order");

  a_offer_one_result : assert property (@(posedge clk) disable iff (rst)
    (in_acc && (kind == KIND_OFFER)) |=> (out_valid && last && !entry_valid))
    else $error("offer result missing");

endmodule

>>> tb/tksi_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tksi_checker: result predictor and scoreboard for top_k_sorted_insertion
// Watches both channels, keeps its own ranked list, queues the results each
// accepted request should give and compares every delivered result with the
// oldest one still due.
// ----------------------------------------------------------------------------
module tksi_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [tksi_pkg::KIND_W-1:0]   kind,
  input  logic [tksi_pkg::SCORE_W-1:0]  cand_score,
  input  logic [tksi_pkg::TAG_W-1:0]    cand_tag,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          accepted,
  input  logic [tksi_pkg::RANK_W-1:0]   rank,
  input  logic [tksi_pkg::SCORE_W-1:0]  entry_score,
  input  logic [tksi_pkg::TAG_W-1:0]    entry_tag,
  input  logic                          entry_valid,
  input  logic                          last,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import tksi_pkg::*;

  typedef struct packed {
    logic               accepted;
    logic [RANK_W-1:0]  rank;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               valid;
    logic               last;
  } list_result_t;

  list_result_t       due_results[$];
  logic [SCORE_W-1:0] ranked_score [DEPTH];
  logic [TAG_W-1:0]   ranked_tag [DEPTH];
  int unsigned        ranked_count;
  int                 mismatches;
  int                 due_count;
  int                 results_seen;

  assign fail_count = mismatches;
  assign pending    = due_count;
  assign checked    = results_seen;

  function automatic list_result_t make_result(logic acc, logic [RANK_W-1:0] rk,
                                               logic [SCORE_W-1:0] sc,
                                               logic [TAG_W-1:0] tg, logic vl,
                                               logic ls);
    list_result_t r;
    r.accepted = acc;
    r.rank     = rk;
    r.score    = sc;
    r.tag      = tg;
    r.valid    = vl;
    r.last     = ls;
    return r;
  endfunction

  // Works out the results of one request and updates the ranked list
  function automatic void predict_request(logic [KIND_W-1:0] k, logic [SCORE_W-1:0] s,
                                          logic [TAG_W-1:0] t);
    int unsigned pos;
    case (k)
      KIND_OFFER: begin
        if (s == '0) begin
          due_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
          return;
        end
        pos = ranked_count;
        if (pos < DEPTH) begin
          ranked_count++;
        end else if (s <= ranked_score[DEPTH-1]) begin
          // full and not better than the tail: dropped
          due_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
          return;
        end else begin
          pos = DEPTH - 1;
        end
        // strict compare keeps an equal older entry ahead
        while (pos > 0 && ranked_score[pos-1] < s) begin
          ranked_score[pos] = ranked_score[pos-1];
          ranked_tag[pos]   = ranked_tag[pos-1];
          pos--;
        end
        ranked_score[pos] = s;
        ranked_tag[pos]   = t;
        due_results.push_back(make_result(1'b1, RANK_W'(pos), '0, '0, 1'b0, 1'b1));
      end
      KIND_REPORT: begin
        if (ranked_count == 0) begin
          due_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          for (int unsigned i = 0; i < ranked_count; i++) begin
            due_results.push_back(make_result(1'b0, RANK_W'(i), ranked_score[i],
                                              ranked_tag[i], 1'b1,
                                              (i + 1 == ranked_count)));
          end
        end
      end
      KIND_CLEAR: begin
        ranked_count = 0;
      end
      default: begin
        // unused kind: ignored
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    ranked_count = 0;
    mismatches   = 0;
    due_count    = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      due_results.delete();
      ranked_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result with nothing due: rank 0x%0h score 0x%0h tag 0x%0h",
                 rank, entry_score, entry_tag);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("accepted", want.accepted, accepted);
          check_field("rank", want.rank, rank);
          check_field("entry_score", want.score, entry_score);
          check_field("entry_tag", want.tag, entry_tag);
          check_field("entry_valid", want.valid, entry_valid);
          check_field("last", want.last, last);
        end
      end
      if (in_valid && !in_stall) begin
        predict_request(kind, cand_score, cand_tag);
      end
    end
    due_count = due_results.size();
  end

endmodule

>>> tb/tb_top_k_sorted_insertion.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_insertion: regression for the top-k insertion list
// Directed corner requests, then random offer/report/clear traffic with
// bursty gaps on both channels, one long output hold and a drain pause.
// ----------------------------------------------------------------------------
module tb_top_k_sorted_insertion;
  import tksi_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 12;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [KIND_W-1:0]  kind;
  logic [SCORE_W-1:0] cand_score;
  logic [TAG_W-1:0]   cand_tag;
  logic               out_valid;
  logic               out_stall;
  logic               accepted;
  logic [RANK_W-1:0]  rank;
  logic [SCORE_W-1:0] entry_score;
  logic [TAG_W-1:0]   entry_tag;
  logic               entry_valid;
  logic               last;

  int   fail_count;
  int   pending;
  int   checked;
  logic in_took;
  logic tx_bursty;
  logic rx_bursty;
  logic hold_out;
  int   n_offer;
  int   n_report;
  int   n_clear;
  int   n_unused;
  int   idle_cycles;

  top_k_sorted_insertion i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .cand_score  (cand_score),
    .cand_tag    (cand_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .rank        (rank),
    .entry_score (entry_score),
    .entry_tag   (entry_tag),
    .entry_valid (entry_valid),
    .last        (last)
  );

  tksi_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .cand_score  (cand_score),
    .cand_tag    (cand_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .rank        (rank),
    .entry_score (entry_score),
    .entry_tag   (entry_tag),
    .entry_valid (entry_valid),
    .last        (last),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_OFFER;
    cand_score = '0;
    cand_tag   = '0;
    out_stall  = 1'b0;
    in_took    = 1'b0;
    tx_bursty  = 1'b1;
    rx_bursty  = 1'b1;
    hold_out   = 1'b0;
  end

  always #4 clk = ~clk;

  // registered view of the input handshake, read by the driver at negedge
  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
  end

  // Receiver: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_out = 1'b0;
      end else if (rx_bursty && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any request or result moving
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("top_k_sorted_insertion regression: fail");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [KIND_W-1:0] k, input logic [SCORE_W-1:0] s,
                          input logic [TAG_W-1:0] t);
    if (tx_bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    cand_score <= s;
    cand_tag   <= t;
    do @(negedge clk); while (!in_took);
    case (k)
      KIND_OFFER:  n_offer++;
      KIND_REPORT: n_report++;
      KIND_CLEAR:  n_clear++;
      default:     n_unused++;
    endcase
  endtask

  // Mix of zero, narrow (ties, full-list drops), wide and maximum scores
  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r <= 3) return SCORE_W'($urandom_range(1, 16));
    if (r <= 6) return SCORE_W'($urandom_range(1, 65535));
    if (r == 7) return '1;
    return SCORE_W'($urandom_range(100, 140));
  endfunction

  task automatic send_random(input int count);
    int                done;
    int unsigned       r;
    logic [KIND_W-1:0] k;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 76)      k = KIND_OFFER;
      else if (r < 90) k = KIND_REPORT;
      else if (r < 97) k = KIND_CLEAR;
      else             k = KIND_UNUSED;
      send_req(k, pick_score(), TAG_W'($urandom_range(0, 65535)));
      // unused kinds are ignored by the block and don't count
      if (k != KIND_UNUSED) done++;
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    n_offer  = 0;
    n_report = 0;
    n_clear  = 0;
    n_unused = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty report, zero score, extremes, ties, full-list edges
    send_req(KIND_REPORT, 16'h1234, 16'h5678);
    send_req(KIND_OFFER, 16'h0000, 16'hFFFF);
    send_req(KIND_OFFER, 16'hFFFF, 16'hFFFF);
    send_req(KIND_OFFER, 16'h0001, 16'h0000);
    send_req(KIND_OFFER, 16'd100, 16'h00A1);
    send_req(KIND_OFFER, 16'd100, 16'h00A2);
    send_req(KIND_OFFER, 16'd500, 16'h0105);
    send_req(KIND_OFFER, 16'd300, 16'h0103);
    send_req(KIND_OFFER, 16'd200, 16'h0102);
    send_req(KIND_OFFER, 16'd50, 16'h0050);
    send_req(KIND_OFFER, 16'd7, 16'h0007);
    send_req(KIND_OFFER, 16'd2, 16'h0002);
    send_req(KIND_REPORT, 16'h0000, 16'h0000);
    // list is full: tail equal is dropped, better evicts the tail
    send_req(KIND_OFFER, 16'd1, 16'hBEEF);
    send_req(KIND_OFFER, 16'd2, 16'hC002);
    send_req(KIND_OFFER, 16'hFFFF, 16'h8001);
    send_req(KIND_OFFER, 16'h0000, 16'h0000);
    send_req(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    send_req(KIND_REPORT, 16'hFFFF, 16'hFFFF);
    send_req(KIND_CLEAR, 16'hFFFF, 16'hFFFF);
    send_req(KIND_REPORT, 16'h0000, 16'h0000);
    send_req(KIND_CLEAR, 16'h0000, 16'h0000);

    // random traffic with gaps on both sides
    send_random(60);

    // long output hold while requests keep coming, then drain
    tx_bursty = 1'b0;
    hold_out  = 1'b1;
    send_random(30);
    in_valid <= 1'b0;
    wait_drained();

    // stretch with no idling, then bursty again, then a quiet tail
    rx_bursty = 1'b0;
    send_random(40);
    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    send_random(50);
    tx_bursty = 1'b0;
    rx_bursty = 1'b0;
    send_random(30);
    in_valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d offers, %0d reports, %0d clears, %0d unused-kind requests",
             n_offer, n_report, n_clear, n_unused);
    $display("%0d results checked, with one long output hold and a drain pause", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("top_k_sorted_insertion regression: pass");
    end else begin
      $display("top_k_sorted_insertion regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tksi_pkg.sv
rtl/tksi_cell.sv
rtl/top_k_sorted_insertion.sv
tb/tksi_checker.sv
tb/tb_top_k_sorted_insertion.sv
